### rtl/m2d_pkg.sv
// ----------------------------------------------------------------------------
// m2d_pkg
// Shared types and constants for the 2x2 determinant, inverse and eigenvalue
// pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package m2d_pkg;

  // Field widths.
  localparam int ENTRY_W = 16;
  localparam int DET_W   = 33;
  localparam int DMAG_W  = 32;
  localparam int EPS_W   = 31;
  localparam int INV_W   = 32;
  localparam int EIG_W   = 19;
  localparam int TRACE_W = 18;

  // Divider: 16-bit magnitude shifted up by 24 gives a 40-bit dividend.
  localparam int FRAC_SH   = 24;
  localparam int NUM_W     = ENTRY_W + FRAC_SH;
  localparam int REM_W     = DMAG_W + 1;
  localparam int DIV_STEPS = NUM_W;
  localparam int LANES     = 4;

  // Square root: 36-bit radicand, two bits per step.
  localparam int RAD_W      = 2 * TRACE_W;
  localparam int ROOT_W     = TRACE_W;
  localparam int SREM_W     = ROOT_W + 3;
  localparam int SQRT_STEPS = RAD_W / 2;

  // One divider lane: dividend shifting out, remainder, quotient shifting in.
  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [REM_W-1:0] rem;
    logic [NUM_W-1:0] quo;
    logic             neg;
  } div_lane_t;

  // Everything one matrix carries down the iterative part of the pipeline.
  typedef struct packed {
    logic                      valid;
    logic signed [DET_W-1:0]   det;
    logic [1:0]                rank;
    logic                      regular;
    logic [DMAG_W-1:0]         dmag;
    div_lane_t [LANES-1:0]     lane;
    logic [RAD_W-1:0]          rad;
    logic [SREM_W-1:0]         srem;
    logic [ROOT_W-1:0]         root;
    logic signed [TRACE_W-1:0] trace;
    logic                      real_eig;
  } pipe_t;

endpackage

`default_nettype wire

### rtl/matrix2x2_det_inverse_eigen.sv
// Pipeline: 3 front stages, 40 divider stages that also carry the 18
// square-root stages, and 1 output register.
// Throughput: one matrix per cycle; the whole pipeline holds while a result
// waits at the output, so a stall loses no request.
// Reset: synchronous rst clears all valid bits and sets det_epsilon to 0.
// ----------------------------------------------------------------------------
// matrix2x2_det_inverse_eigen
// Determinant, rank, truncated Q15.16 inverse and floor eigenvalues of a
// stream of 2x2 Q7.8 matrices.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix2x2_det_inverse_eigen (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [m2d_pkg::EPS_W-1:0]         cfg_wdata,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic signed [m2d_pkg::ENTRY_W-1:0] entry_a00,
  input  wire logic signed [m2d_pkg::ENTRY_W-1:0] entry_a01,
  input  wire logic signed [m2d_pkg::ENTRY_W-1:0] entry_a10,
  input  wire logic signed [m2d_pkg::ENTRY_W-1:0] entry_a11,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic signed [m2d_pkg::DET_W-1:0]       det_value,
  output logic [1:0]                             rank_value,
  output logic                                   inv_valid,
  output logic signed [m2d_pkg::INV_W-1:0]       inv_00,
  output logic signed [m2d_pkg::INV_W-1:0]       inv_01,
  output logic signed [m2d_pkg::INV_W-1:0]       inv_10,
  output logic signed [m2d_pkg::INV_W-1:0]       inv_11,
  output logic                                   inv_clipped,
  output logic                                   eig_real,
  output logic signed [m2d_pkg::EIG_W-1:0]       eig_large,
  output logic signed [m2d_pkg::EIG_W-1:0]       eig_small
);
  import m2d_pkg::*;

  logic              en;
  logic [EPS_W-1:0]  det_epsilon;
  pipe_t             stg [DIV_STEPS+1];

  // The pipeline advances whenever the output register is free or drained.
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // Singularity threshold register.
  always_ff @(posedge clk) begin
    if (rst) begin
      det_epsilon <= '0;
    end else if (cfg_we) begin
      det_epsilon <= cfg_wdata;
    end
  end

  // Products, determinant, rank and operand setup.
  m2d_front u_front (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_take (in_valid),
    .a00     (entry_a00),
    .a01     (entry_a01),
    .a10     (entry_a10),
    .a11     (entry_a11),
    .eps     (det_epsilon),
    .pipe    (stg[0])
  );

  // One quotient bit per stage; the root is finished in the first stages.
  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
    m2d_step u_step (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .sqrt_on (i < SQRT_STEPS),
      .pin     (stg[i]),
      .pout    (stg[i+1])
    );
  end

  // Sign, saturation, halving and the result register.
  m2d_back u_back (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .pin         (stg[DIV_STEPS]),
    .out_valid   (out_valid),
    .det_value   (det_value),
    .rank_value  (rank_value),
    .inv_valid   (inv_valid),
    .inv_00      (inv_00),
    .inv_01      (inv_01),
    .inv_10      (inv_10),
    .inv_11      (inv_11),
    .inv_clipped (inv_clipped),
    .eig_real    (eig_real),
    .eig_large   (eig_large),
    .eig_small   (eig_small)
  );

endmodule

`default_nettype wire

### rtl/m2d_front.sv
// ----------------------------------------------------------------------------
// m2d_front
// Three register stages: products, determinant and trace square, then the
// rank test, discriminant and divider/root operands.
// ----------------------------------------------------------------------------
`default_nettype none

module m2d_front (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                en,
  input  wire logic                                in_take,
  input  wire logic signed [m2d_pkg::ENTRY_W-1:0]  a00,
  input  wire logic signed [m2d_pkg::ENTRY_W-1:0]  a01,
  input  wire logic signed [m2d_pkg::ENTRY_W-1:0]  a10,
  input  wire logic signed [m2d_pkg::ENTRY_W-1:0]  a11,
  input  wire logic [m2d_pkg::EPS_W-1:0]           eps,
  output m2d_pkg::pipe_t                           pipe
);
  import m2d_pkg::*;

  // Magnitude of a signed entry; the most negative value maps to 2^15.
  function automatic logic [ENTRY_W-1:0] abs16(input logic signed [ENTRY_W-1:0] x);
    abs16 = x[ENTRY_W-1] ? ENTRY_W'(-x) : ENTRY_W'(x);
  endfunction

  // Stage 1 registers.
  logic                            v1;
  logic signed [ENTRY_W-1:0]       s1_a, s1_b, s1_c, s1_d;
  logic signed [2*ENTRY_W-1:0]     s1_p0, s1_p1;
  logic signed [TRACE_W-1:0]       s1_trace;

  // Stage 2 registers.
  logic                            v2;
  logic signed [ENTRY_W-1:0]       s2_a, s2_b, s2_c, s2_d;
  logic signed [DET_W-1:0]         s2_det;
  logic [RAD_W-1:0]                s2_tsq;
  logic signed [TRACE_W-1:0]       s2_trace;

  logic signed [2*TRACE_W-1:0]     tsq_full;
  logic signed [RAD_W:0]           disc;
  logic [DET_W-1:0]                dmag_full;
  logic [ENTRY_W-1:0]              mag [LANES];
  logic                            sgn [LANES];
  pipe_t                           pipe_next;

  // Stage 1: the two cross products and the trace.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_take;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_a     <= a00;
      s1_b     <= a01;
      s1_c     <= a10;
      s1_d     <= a11;
      s1_p0    <= a00 * a11;
      s1_p1    <= a01 * a10;
      s1_trace <= TRACE_W'(a00) + TRACE_W'(a11);
    end
  end

  // Stage 2: determinant and the square of the trace.
  assign tsq_full = s1_trace * s1_trace;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_a     <= s1_a;
      s2_b     <= s1_b;
      s2_c     <= s1_c;
      s2_d     <= s1_d;
      s2_det   <= DET_W'(s1_p0) - DET_W'(s1_p1);
      s2_tsq   <= RAD_W'(tsq_full);
      s2_trace <= s1_trace;
    end
  end

  // Stage 3: rank, discriminant and the operands of the iterative units.
  assign disc      = $signed({1'b0, s2_tsq}) - $signed({{2{s2_det[DET_W-1]}}, s2_det, 2'b00});
  assign dmag_full = s2_det[DET_W-1] ? DET_W'(-s2_det) : DET_W'(s2_det);

  // Numerators of the adjugate: d, -b, -c, a.
  always_comb begin
    mag[0] = abs16(s2_d);
    mag[1] = abs16(s2_b);
    mag[2] = abs16(s2_c);
    mag[3] = abs16(s2_a);
    sgn[0] = s2_d[ENTRY_W-1];
    sgn[1] = (s2_b != '0) && !s2_b[ENTRY_W-1];
    sgn[2] = (s2_c != '0) && !s2_c[ENTRY_W-1];
    sgn[3] = s2_a[ENTRY_W-1];
  end

  always_comb begin
    pipe_next          = '0;
    pipe_next.valid    = v2;
    pipe_next.det      = s2_det;
    pipe_next.dmag     = dmag_full[DMAG_W-1:0];
    pipe_next.regular  = dmag_full[DMAG_W-1:0] > {1'b0, eps};
    if (pipe_next.regular) begin
      pipe_next.rank = 2'd2;
    end else if (s2_a != '0 || s2_b != '0 || s2_c != '0 || s2_d != '0) begin
      pipe_next.rank = 2'd1;
    end else begin
      pipe_next.rank = 2'd0;
    end
    for (int k = 0; k < LANES; k++) begin
      pipe_next.lane[k].num = {mag[k], {FRAC_SH{1'b0}}};
      pipe_next.lane[k].rem = '0;
      pipe_next.lane[k].quo = '0;
      pipe_next.lane[k].neg = sgn[k] ^ s2_det[DET_W-1];
    end
    pipe_next.real_eig = !disc[RAD_W];
    pipe_next.rad      = disc[RAD_W] ? '0 : disc[RAD_W-1:0];
    pipe_next.srem     = '0;
    pipe_next.root     = '0;
    pipe_next.trace    = s2_trace;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pipe.valid <= 1'b0;
    end else if (en) begin
      pipe <= pipe_next;
    end
  end

endmodule

`default_nettype wire

### rtl/m2d_step.sv
// ----------------------------------------------------------------------------
// m2d_step
// One pipeline stage of the iterative part: one quotient bit in each of the
// four divider lanes and, where enabled, one root bit of the square root.
// ----------------------------------------------------------------------------
`default_nettype none

module m2d_step (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       en,
  input  wire logic       sqrt_on,
  input  m2d_pkg::pipe_t  pin,
  output m2d_pkg::pipe_t  pout
);
  import m2d_pkg::*;

  pipe_t              pout_next;
  logic [REM_W-1:0]   r_sh [LANES];
  logic [SREM_W-1:0]  t_sh;
  logic [SREM_W-1:0]  trial;

  always_comb begin
    pout_next = pin;

    // Restoring division step, shared divisor across the lanes.
    for (int k = 0; k < LANES; k++) begin
      r_sh[k] = {pin.lane[k].rem[REM_W-2:0], pin.lane[k].num[NUM_W-1]};
      pout_next.lane[k].num = {pin.lane[k].num[NUM_W-2:0], 1'b0};
      if (r_sh[k] >= {1'b0, pin.dmag}) begin
        pout_next.lane[k].rem = r_sh[k] - {1'b0, pin.dmag};
        pout_next.lane[k].quo = {pin.lane[k].quo[NUM_W-2:0], 1'b1};
      end else begin
        pout_next.lane[k].rem = r_sh[k];
        pout_next.lane[k].quo = {pin.lane[k].quo[NUM_W-2:0], 1'b0};
      end
    end

    // Digit-by-digit square root step, two radicand bits at a time.
    t_sh  = {pin.srem[SREM_W-3:0], pin.rad[RAD_W-1:RAD_W-2]};
    trial = {1'b0, pin.root, 2'b01};
    if (sqrt_on) begin
      pout_next.rad = {pin.rad[RAD_W-3:0], 2'b00};
      if (t_sh >= trial) begin
        pout_next.srem = t_sh - trial;
        pout_next.root = {pin.root[ROOT_W-2:0], 1'b1};
      end else begin
        pout_next.srem = t_sh;
        pout_next.root = {pin.root[ROOT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pout.valid <= 1'b0;
    end else if (en) begin
      pout <= pout_next;
    end
  end

endmodule

`default_nettype wire

### rtl/m2d_back.sv
// ----------------------------------------------------------------------------
// m2d_back
// Final stage: signs and saturation of the inverse, eigenvalue halving, and
// the output register of the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module m2d_back (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              en,
  input  m2d_pkg::pipe_t                         pin,
  output logic                                   out_valid,
  output logic signed [m2d_pkg::DET_W-1:0]       det_value,
  output logic [1:0]                             rank_value,
  output logic                                   inv_valid,
  output logic signed [m2d_pkg::INV_W-1:0]       inv_00,
  output logic signed [m2d_pkg::INV_W-1:0]       inv_01,
  output logic signed [m2d_pkg::INV_W-1:0]       inv_10,
  output logic signed [m2d_pkg::INV_W-1:0]       inv_11,
  output logic                                   inv_clipped,
  output logic                                   eig_real,
  output logic signed [m2d_pkg::EIG_W-1:0]       eig_large,
  output logic signed [m2d_pkg::EIG_W-1:0]       eig_small
);
  import m2d_pkg::*;

  localparam logic [NUM_W-1:0] POS_MAX = NUM_W'(32'h7FFF_FFFF);
  localparam logic [NUM_W-1:0] NEG_MAX = NUM_W'(32'h8000_0000);

  logic [INV_W-1:0]        inv_q [LANES];
  logic [LANES-1:0]        clip;
  logic signed [EIG_W:0]   sum_l, sum_s;

  // Truncated quotient with sign, clamped to the 32-bit range; zero when not regular.
  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      if (!pin.regular) begin
        clip[k]  = 1'b0;
        inv_q[k] = '0;
      end else if (!pin.lane[k].neg) begin
        clip[k]  = pin.lane[k].quo > POS_MAX;
        inv_q[k] = clip[k] ? POS_MAX[INV_W-1:0] : pin.lane[k].quo[INV_W-1:0];
      end else begin
        clip[k]  = pin.lane[k].quo > NEG_MAX;
        inv_q[k] = clip[k] ? NEG_MAX[INV_W-1:0] : INV_W'(-pin.lane[k].quo[INV_W-1:0]);
      end
    end
  end

  // Eigenvalues: (trace +/- root) halved with floor.
  assign sum_l = (EIG_W+1)'(pin.trace) + (EIG_W+1)'(pin.root);
  assign sum_s = (EIG_W+1)'(pin.trace) - (EIG_W+1)'(pin.root);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= pin.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      det_value   <= pin.det;
      rank_value  <= pin.rank;
      inv_valid   <= pin.regular;
      inv_00      <= inv_q[0];
      inv_01      <= inv_q[1];
      inv_10      <= inv_q[2];
      inv_11      <= inv_q[3];
      inv_clipped <= |clip;
      eig_real    <= pin.real_eig;
      eig_large   <= pin.real_eig ? sum_l[EIG_W:1] : '0;
      eig_small   <= pin.real_eig ? sum_s[EIG_W:1] : '0;
    end
  end

endmodule

`default_nettype wire
